/* sv/hba_pkg.sv */
// hba_pkg: shared types and constants of the heap block allocator
// used by the channel interfaces and the top level
package hba_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int ADDR_BITS    = 20;
    localparam int SIZE_W       = 20;
    localparam int OFF_W        = ADDR_BITS + 1;
    localparam int HEADER_BYTES = 24;
    localparam int LIMIT_W      = 21;
    localparam int MERGE_W      = 7;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_SPACE    = 2'd1,
        ST_ZERO_SIZE   = 2'd2,
        ST_BAD_RELEASE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2,
        POL_NEXT  = 2'd3
    } policy_t;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic {
        CFG_POLICY = 1'b0,
        CFG_LIMIT  = 1'b1
    } cfg_index_t;

endpackage

/* sv/hba_req_if.sv */
// hba_req_if: request channel of the heap block allocator
// depends on hba_pkg for field widths
interface hba_req_if
    import hba_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [SIZE_W-1:0]    request_size;
    logic [ADDR_BITS-1:0] data_address;

    modport source (output valid, output operation, output request_size,
                    output data_address, input ready);
    modport sink (input valid, input operation, input request_size,
                  input data_address, output ready);
endinterface

/* sv/hba_rsp_if.sv */
// hba_rsp_if: response channel of the heap block allocator
// depends on hba_pkg for field widths
interface hba_rsp_if
    import hba_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] result_address;
    logic                 was_reused;
    logic                 was_split;
    logic [MERGE_W-1:0]   merges_done;

    modport source (output valid, output status, output result_address,
                    output was_reused, output was_split, output merges_done,
                    input ready);
    modport sink (input valid, input status, input result_address,
                  input was_reused, input was_split, input merges_done,
                  output ready);
endinterface

/* sv/hba_ram.sv */
// hba_ram: generic one-write one-read ram with registered read data
// standalone, no package dependency
module hba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* sv/heap_block_allocator.sv */
// heap_block_allocator: top level, sequencer over the segment size ram
// depends on hba_pkg, hba_req_if, hba_rsp_if and hba_ram

// One request is handled at a time. Every request but a zero-size allocate
// first scans the segment table of at most 64 segments through the single
// read port of the size ram, one segment a cycle, then decides in S_DECIDE.
// An allocate that splits a segment then moves the entries above it up by
// one (one entry a cycle) and writes the two halves; a release that
// succeeds compacts the whole table in a second pass. A zero-size allocate
// goes from the idle state straight to S_DONE. Each request keeps the input
// busy until its result is placed in the output register, waiting first for
// any response that has not been taken yet. The response sits in an output
// register, so the next request can be taken while it waits. Configuration
// writes are meant to come only while the block is idle.
module heap_block_allocator
    import hba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [LIMIT_W-1:0] cfg_data,
    hba_req_if.sink            req,
    hba_rsp_if.source          rsp
);
    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_SCAN      = 9'b000000010,
        S_DECIDE    = 9'b000000100,
        S_SHIFT     = 9'b000001000,
        S_SPLIT_HI  = 9'b000010000,
        S_SPLIT_LO  = 9'b000100000,
        S_MERGE     = 9'b001000000,
        S_MERGE_END = 9'b010000000,
        S_DONE      = 9'b100000000
    } state_t;

    localparam logic [OFF_W-1:0] HDR     = OFF_W'(HEADER_BYTES);
    localparam logic [OFF_W-1:0] HDR2    = OFF_W'(2 * HEADER_BYTES);
    localparam logic [OFF_W:0]   ADDR_CAP = (OFF_W+1)'(1) << ADDR_BITS;

    state_t               state_reg, state_next;
    logic                 op_reg, op_next;
    logic [OFF_W-1:0]     need_reg, need_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [OFF_W-1:0]     off_reg, off_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pidx_reg, pidx_next;
    logic [OFF_W-1:0]     poff_reg, poff_next;
    logic [SIZE_W-1:0]    psize_reg, psize_next;
    logic                 found2_reg, found2_next;
    logic [IDX_W-1:0]     p2idx_reg, p2idx_next;
    logic [OFF_W-1:0]     p2off_reg, p2off_next;
    logic [SIZE_W-1:0]    p2size_reg, p2size_next;
    logic [CNT_W-1:0]     sj_reg, sj_next;
    logic                 have_reg, have_next;
    logic [IDX_W-1:0]     wdst_reg, wdst_next;
    logic [CNT_W-1:0]     w_reg, w_next;
    logic [SIZE_W-1:0]    acc_size_reg, acc_size_next;
    logic                 acc_free_reg, acc_free_next;
    logic [MERGE_W-1:0]   merges_reg, merges_next;
    status_t              res_status_reg, res_status_next;
    logic [ADDR_BITS-1:0] res_addr_reg, res_addr_next;
    logic                 res_reused_reg, res_reused_next;
    logic                 res_split_reg, res_split_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [OFF_W-1:0]     heap_end_reg, heap_end_next;
    logic [ADDR_BITS-1:0] rover_reg, rover_next;
    policy_t              policy_reg, policy_next;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;
    logic [MAX_SEGMENTS-1:0] free_reg, free_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [ADDR_BITS-1:0] out_addr_reg, out_addr_next;
    logic                 out_reused_reg, out_reused_next;
    logic                 out_split_reg, out_split_next;
    logic [MERGE_W-1:0]   out_merges_reg, out_merges_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [SIZE_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [SIZE_W-1:0]    ram_rdata;

    hba_ram #(
        .WIDTH(SIZE_W),
        .DEPTH(MAX_SEGMENTS)
    ) u_size_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.result_address = out_addr_reg;
    assign rsp.was_reused     = out_reused_reg;
    assign rsp.was_split      = out_split_reg;
    assign rsp.merges_done    = out_merges_reg;

    logic [IDX_W-1:0]  p_idx;
    logic              e_free;
    logic              fit;
    logic [IDX_W-1:0]  sel_idx;
    logic [OFF_W-1:0]  sel_off;
    logic [SIZE_W-1:0] sel_size;
    logic [OFF_W+1:0]  grow_sum;
    logic [OFF_W:0]    eff_limit;
    logic [OFF_W-1:0]  rounded;

    always_comb
    begin
        p_idx    = IDX_W'(k_reg - CNT_W'(1));
        e_free   = free_reg[p_idx];
        fit      = e_free && ({1'b0, ram_rdata} >= need_reg);
        sel_idx  = (policy_reg == POL_NEXT && found2_reg) ? p2idx_reg : pidx_reg;
        sel_off  = (policy_reg == POL_NEXT && found2_reg) ? p2off_reg : poff_reg;
        sel_size = (policy_reg == POL_NEXT && found2_reg) ? p2size_reg : psize_reg;
        grow_sum = {1'b0, heap_end_reg} + {2'b0, HDR} + {1'b0, need_reg};
        eff_limit = ({1'b0, limit_reg} > ADDR_CAP) ? ADDR_CAP : {1'b0, limit_reg};
        rounded  = ({1'b0, req.request_size} + OFF_W'(3)) & ~OFF_W'(3);
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        need_next       = need_reg;
        addr_next       = addr_reg;
        k_next          = k_reg;
        off_next        = off_reg;
        found_next      = found_reg;
        pidx_next       = pidx_reg;
        poff_next       = poff_reg;
        psize_next      = psize_reg;
        found2_next     = found2_reg;
        p2idx_next      = p2idx_reg;
        p2off_next      = p2off_reg;
        p2size_next     = p2size_reg;
        sj_next         = sj_reg;
        have_next       = have_reg;
        wdst_next       = wdst_reg;
        w_next          = w_reg;
        acc_size_next   = acc_size_reg;
        acc_free_next   = acc_free_reg;
        merges_next     = merges_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_reused_next = res_reused_reg;
        res_split_next  = res_split_reg;
        count_next      = count_reg;
        heap_end_next   = heap_end_reg;
        rover_next      = rover_reg;
        policy_next     = policy_reg;
        limit_next      = limit_reg;
        free_next       = free_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_reused_next = out_reused_reg;
        out_split_next  = out_split_reg;
        out_merges_next = out_merges_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = k_reg[IDX_W-1:0];

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_POLICY: policy_next = policy_t'(cfg_data[1:0]);
                CFG_LIMIT:  limit_next  = cfg_data;
                default:    ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = req.operation;
                    need_next       = rounded;
                    addr_next       = req.data_address;
                    k_next          = '0;
                    off_next        = '0;
                    found_next      = 1'b0;
                    found2_next     = 1'b0;
                    merges_next     = '0;
                    res_status_next = ST_OK;
                    res_addr_next   = '0;
                    res_reused_next = 1'b0;
                    res_split_next  = 1'b0;
                    if (op_t'(req.operation) == OP_ALLOC && rounded == '0)
                    begin
                        res_status_next = ST_ZERO_SIZE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (k_reg != '0)
                begin
                    // ram_rdata holds the size of segment k-1 at offset off_reg
                    if (op_t'(op_reg) == OP_RELEASE)
                    begin
                        if (!found_reg &&
                            ({1'b0, off_reg} + {1'b0, HDR}) == {2'b0, addr_reg})
                        begin
                            found_next = 1'b1;
                            pidx_next  = p_idx;
                        end
                    end
                    else if (fit)
                    begin
                        case (policy_reg)
                            POL_FIRST, POL_NEXT:
                            begin
                                if (!found_reg)
                                begin
                                    found_next = 1'b1;
                                    pidx_next  = p_idx;
                                    poff_next  = off_reg;
                                    psize_next = ram_rdata;
                                end
                            end
                            POL_BEST:
                            begin
                                if (!found_reg || ram_rdata < psize_reg)
                                begin
                                    found_next = 1'b1;
                                    pidx_next  = p_idx;
                                    poff_next  = off_reg;
                                    psize_next = ram_rdata;
                                end
                            end
                            POL_WORST:
                            begin
                                if (!found_reg || ram_rdata > psize_reg)
                                begin
                                    found_next = 1'b1;
                                    pidx_next  = p_idx;
                                    poff_next  = off_reg;
                                    psize_next = ram_rdata;
                                end
                            end
                            default: ;
                        endcase
                        // next fit prefers the first fit at or past the rover
                        if (!found2_reg && off_reg >= {1'b0, rover_reg})
                        begin
                            found2_next = 1'b1;
                            p2idx_next  = p_idx;
                            p2off_next  = off_reg;
                            p2size_next = ram_rdata;
                        end
                    end
                    off_next = off_reg + HDR + {1'b0, ram_rdata};
                end
                if (k_reg == count_reg)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    k_next = k_reg + CNT_W'(1);
                end
            end

            S_DECIDE:
            begin
                if (op_t'(op_reg) == OP_RELEASE)
                begin
                    if (!found_reg || free_reg[pidx_reg])
                    begin
                        res_status_next = ST_BAD_RELEASE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        free_next[pidx_reg] = 1'b1;
                        k_next              = '0;
                        w_next              = '0;
                        state_next          = S_MERGE;
                    end
                end
                else if (found_reg)
                begin
                    res_addr_next      = ADDR_BITS'(sel_off + HDR);
                    res_reused_next    = 1'b1;
                    free_next[sel_idx] = 1'b0;
                    pidx_next          = sel_idx;
                    psize_next         = sel_size;
                    if (policy_reg == POL_NEXT)
                    begin
                        rover_next = sel_off[ADDR_BITS-1:0];
                    end
                    if ({1'b0, sel_size} >= need_reg + HDR2 &&
                        count_reg < CNT_W'(MAX_SEGMENTS))
                    begin
                        res_split_next = 1'b1;
                        sj_next        = count_reg;
                        have_next      = 1'b0;
                        state_next     = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    if (policy_reg == POL_NEXT)
                    begin
                        rover_next = '0;
                    end
                    if (count_reg < CNT_W'(MAX_SEGMENTS) &&
                        grow_sum <= {1'b0, eff_limit})
                    begin
                        ram_we                = 1'b1;
                        ram_waddr             = count_reg[IDX_W-1:0];
                        ram_wdata             = need_reg[SIZE_W-1:0];
                        free_next[count_reg[IDX_W-1:0]] = 1'b0;
                        count_next            = count_reg + CNT_W'(1);
                        res_addr_next         = ADDR_BITS'(heap_end_reg + HDR);
                        heap_end_next         = OFF_W'(grow_sum);
                    end
                    else
                    begin
                        res_status_next = ST_NO_SPACE;
                    end
                    state_next = S_DONE;
                end
            end

            S_SHIFT:
            begin
                // move entries above the split one place up, top first
                if (have_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wdst_reg;
                    ram_wdata = ram_rdata;
                    free_next[wdst_reg] = free_reg[wdst_reg - IDX_W'(1)];
                end
                if (sj_reg > {1'b0, pidx_reg} + CNT_W'(1))
                begin
                    ram_raddr = IDX_W'(sj_reg - CNT_W'(1));
                    wdst_next = sj_reg[IDX_W-1:0];
                    sj_next   = sj_reg - CNT_W'(1);
                    have_next = 1'b1;
                end
                else
                begin
                    have_next  = 1'b0;
                    state_next = S_SPLIT_HI;
                end
            end

            S_SPLIT_HI:
            begin
                ram_we    = 1'b1;
                ram_waddr = pidx_reg + IDX_W'(1);
                ram_wdata = SIZE_W'({1'b0, psize_reg} - need_reg - HDR);
                free_next[pidx_reg + IDX_W'(1)] = 1'b1;
                state_next = S_SPLIT_LO;
            end

            S_SPLIT_LO:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pidx_reg;
                ram_wdata  = need_reg[SIZE_W-1:0];
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end

            S_MERGE:
            begin
                // streaming compaction: acc holds the run being built
                if (k_reg != '0)
                begin
                    if (k_reg == CNT_W'(1))
                    begin
                        acc_size_next = ram_rdata;
                        acc_free_next = e_free;
                    end
                    else if (acc_free_reg && e_free)
                    begin
                        acc_size_next = SIZE_W'({1'b0, acc_size_reg} + HDR
                                                + {1'b0, ram_rdata});
                        merges_next   = merges_reg + MERGE_W'(1);
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = w_reg[IDX_W-1:0];
                        ram_wdata = acc_size_reg;
                        free_next[w_reg[IDX_W-1:0]] = acc_free_reg;
                        w_next        = w_reg + CNT_W'(1);
                        acc_size_next = ram_rdata;
                        acc_free_next = e_free;
                    end
                end
                if (k_reg == count_reg)
                begin
                    state_next = S_MERGE_END;
                end
                else
                begin
                    k_next = k_reg + CNT_W'(1);
                end
            end

            S_MERGE_END:
            begin
                ram_we     = 1'b1;
                ram_waddr  = w_reg[IDX_W-1:0];
                ram_wdata  = acc_size_reg;
                free_next[w_reg[IDX_W-1:0]] = acc_free_reg;
                count_next = w_reg + CNT_W'(1);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_reused_next = res_reused_reg;
                    out_split_next  = res_split_reg;
                    out_merges_next = merges_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= 1'b0;
            need_reg       <= '0;
            addr_reg       <= '0;
            k_reg          <= '0;
            off_reg        <= '0;
            found_reg      <= 1'b0;
            pidx_reg       <= '0;
            poff_reg       <= '0;
            psize_reg      <= '0;
            found2_reg     <= 1'b0;
            p2idx_reg      <= '0;
            p2off_reg      <= '0;
            p2size_reg     <= '0;
            sj_reg         <= '0;
            have_reg       <= 1'b0;
            wdst_reg       <= '0;
            w_reg          <= '0;
            acc_size_reg   <= '0;
            acc_free_reg   <= 1'b0;
            merges_reg     <= '0;
            res_status_reg <= ST_OK;
            res_addr_reg   <= '0;
            res_reused_reg <= 1'b0;
            res_split_reg  <= 1'b0;
            count_reg      <= '0;
            heap_end_reg   <= '0;
            rover_reg      <= '0;
            policy_reg     <= POL_FIRST;
            limit_reg      <= LIMIT_W'(1 << ADDR_BITS);
            free_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_addr_reg   <= '0;
            out_reused_reg <= 1'b0;
            out_split_reg  <= 1'b0;
            out_merges_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            need_reg       <= need_next;
            addr_reg       <= addr_next;
            k_reg          <= k_next;
            off_reg        <= off_next;
            found_reg      <= found_next;
            pidx_reg       <= pidx_next;
            poff_reg       <= poff_next;
            psize_reg      <= psize_next;
            found2_reg     <= found2_next;
            p2idx_reg      <= p2idx_next;
            p2off_reg      <= p2off_next;
            p2size_reg     <= p2size_next;
            sj_reg         <= sj_next;
            have_reg       <= have_next;
            wdst_reg       <= wdst_next;
            w_reg          <= w_next;
            acc_size_reg   <= acc_size_next;
            acc_free_reg   <= acc_free_next;
            merges_reg     <= merges_next;
            res_status_reg <= res_status_next;
            res_addr_reg   <= res_addr_next;
            res_reused_reg <= res_reused_next;
            res_split_reg  <= res_split_next;
            count_reg      <= count_next;
            heap_end_reg   <= heap_end_next;
            rover_reg      <= rover_next;
            policy_reg     <= policy_next;
            limit_reg      <= limit_next;
            free_reg       <= free_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_addr_reg   <= out_addr_next;
            out_reused_reg <= out_reused_next;
            out_split_reg  <= out_split_next;
            out_merges_reg <= out_merges_next;
        end
    end
endmodule
